FILE: src/srd_pkg.sv
`default_nettype none
package srd_pkg;

  localparam int FrameMaxBytes = 8;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_WK_START = 5'd1,
    PH_WK_BITS  = 5'd2,
    PH_WK_ACK   = 5'd3,
    PH_WK_HOLD  = 5'd4,
    PH_WK_STOP  = 5'd5,
    PH_WR_START = 5'd6,
    PH_WR_BITS  = 5'd7,
    PH_WR_ACK   = 5'd8,
    PH_WR_STOP  = 5'd9,
    PH_RESP     = 5'd10,
    PH_RD_START = 5'd11,
    PH_RD_ABITS = 5'd12,
    PH_RD_AACK  = 5'd13,
    PH_RD_GAP   = 5'd14,
    PH_RD_BITS  = 5'd15,
    PH_RD_ACK   = 5'd16,
    PH_RD_STOP  = 5'd17,
    PH_DONE     = 5'd18
  } phase_e;

  localparam logic [2:0] REG_DEV_ADDR  = 3'd0;
  localparam logic [2:0] REG_REQ_KIND  = 3'd1;
  localparam logic [2:0] REG_WAKE_HOLD = 3'd2;
  localparam logic [2:0] REG_RESP_WAIT = 3'd3;
  localparam logic [2:0] REG_READ_GAP  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WA_NACK = 2'd1;
  localparam logic [1:0] ST_RQ_NACK = 2'd2;
  localparam logic [1:0] ST_RA_NACK = 2'd3;

  localparam logic [15:0] CrcInit = 16'hffff;
  localparam logic [15:0] CrcPoly = 16'ha001;

  // one byte through the reflected crc16, eight narrow dependent steps
  function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/srd_seq.sv
`default_nettype none
module srd_seq import srd_pkg::*; #(
  parameter int FRAME_MAX_BYTES = FrameMaxBytes
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         step_i,
  input  wire         go_i,
  input  wire         sda_i,
  input  wire  [7:0]  dev_addr_i,
  input  wire         req_kind_i,
  input  wire  [15:0] wake_hold_i,
  input  wire  [15:0] resp_wait_i,
  input  wire  [7:0]  read_gap_i,
  output logic [38:0] res_o
);
  localparam int IW = (FRAME_MAX_BYTES > 1) ? $clog2(FRAME_MAX_BYTES) : 1;

  phase_e      phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [2:0]  bit_q, bit_d;
  logic [3:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] crc_q, crc_d;
  logic [1:0]  err_q, err_d;
  logic [7:0]  frame_q [FRAME_MAX_BYTES];
  logic        fr_we;
  logic [7:0]  fr_wd;

  logic scl, pull, busy, done, crc_ok;
  logic [31:0] data;
  logic [4:0]  len;
  logic [4:0]  lm2, lm1;
  logic [16:0] wnext;
  logic        last;
  phase_e      ph;

  always_comb begin
    len = req_kind_i ? 5'd7 : 5'd8;
    if (len > 5'(FRAME_MAX_BYTES)) len = 5'(FRAME_MAX_BYTES);
    lm2 = len - 5'd2;
    lm1 = len - 5'd1;
  end

  always_comb begin
    phase_d = phase_q; wait_d = wait_q; bit_d = bit_q; byte_d = byte_q;
    shift_d = shift_q; crc_d = crc_q; err_d = err_q;
    scl = 1'b1; pull = 1'b0; busy = 1'b1; done = 1'b0; crc_ok = 1'b0;
    data = '0; fr_we = 1'b0; fr_wd = '0; last = 1'b0;
    wnext = {1'b0, wait_q} + 17'd1;
    ph = phase_q;
    if (phase_q == PH_IDLE && go_i) begin
      ph = PH_WK_START; phase_d = PH_WK_START; wait_d = '0; bit_d = '0; byte_d = '0;
      crc_d = CrcInit; err_d = ST_OK; wnext = 17'd1;
    end
    case (ph)
      PH_WK_START, PH_WR_START, PH_RD_START: begin
        pull = wait_d != 16'd0;
        if (wait_d == 16'd0) wait_d = 16'd1;
        else begin
          phase_d = phase_e'(ph + 5'd1); wait_d = '0; bit_d = '0; byte_d = '0;
          shift_d = (ph == PH_RD_START) ? (dev_addr_i | 8'h01) : dev_addr_i;
        end
      end
      PH_WK_BITS, PH_WR_BITS, PH_RD_ABITS: begin
        pull = ~shift_q[7];
        if (wait_q == 16'd0) begin scl = 1'b0; wait_d = 16'd1; end
        else begin
          wait_d = '0; shift_d = shift_q << 1;
          if (bit_q == 3'd7) begin bit_d = '0; phase_d = phase_e'(ph + 5'd1); end
          else bit_d = bit_q + 3'd1;
        end
      end
      PH_WK_ACK: begin
        if (wait_q == 16'd0) begin scl = 1'b0; wait_d = 16'd1; end
        else begin wait_d = '0; phase_d = PH_WK_HOLD; end
      end
      PH_WK_HOLD, PH_RESP, PH_RD_GAP: begin
        if (ph != PH_RESP) scl = 1'b0;
        if (wnext >= {1'b0, (ph == PH_WK_HOLD) ? wake_hold_i :
                      (ph == PH_RESP) ? resp_wait_i : {8'h00, read_gap_i}}) begin
          wait_d = '0; bit_d = '0;
          case (ph)
            PH_WK_HOLD: phase_d = PH_WK_STOP;
            PH_RESP:    phase_d = PH_RD_START;
            default: begin phase_d = PH_RD_BITS; byte_d = '0; shift_d = '0; end
          endcase
        end else wait_d = wnext[15:0];
      end
      PH_WK_STOP, PH_WR_STOP, PH_RD_STOP: begin
        pull = 1'b1;
        scl = wait_q != 16'd0;
        if (wait_q == 16'd0) wait_d = 16'd1;
        else begin
          wait_d = '0; bit_d = '0;
          if (ph == PH_WK_STOP) phase_d = PH_WR_START;
          else if (ph == PH_WR_STOP) phase_d = PH_RESP;
          else phase_d = PH_DONE;
        end
      end
      PH_WR_ACK: begin
        if (wait_q == 16'd0) begin scl = 1'b0; wait_d = 16'd1; end
        else begin
          wait_d = '0; bit_d = '0;
          if (sda_i) begin
            err_d = (byte_q == 4'd0) ? ST_WA_NACK : ST_RQ_NACK; phase_d = PH_DONE;
          end else if (byte_q >= 4'd3) phase_d = PH_WR_STOP;
          else begin
            byte_d = byte_q + 4'd1; phase_d = PH_WR_BITS;
            case (byte_q)
              4'd0:    shift_d = 8'h03;
              4'd1:    shift_d = req_kind_i ? 8'h08 : 8'h00;
              default: shift_d = req_kind_i ? 8'h07 : 8'h04;
            endcase
          end
        end
      end
      PH_RD_AACK: begin
        if (wait_q == 16'd0) begin scl = 1'b0; wait_d = 16'd1; end
        else begin
          wait_d = '0; bit_d = '0;
          if (sda_i) begin err_d = ST_RA_NACK; phase_d = PH_DONE; end
          else phase_d = PH_RD_GAP;
        end
      end
      PH_RD_BITS: begin
        if (wait_q == 16'd0) begin scl = 1'b0; wait_d = 16'd1; end
        else begin
          wait_d = '0;
          shift_d = {shift_q[6:0], sda_i};
          if (bit_q == 3'd7) begin
            fr_we = {1'b0, byte_q} < 5'(FRAME_MAX_BYTES);
            fr_wd = shift_d;
            if ({1'b0, byte_q} + 5'd2 < len) crc_d = crc_byte(crc_q, shift_d);
            bit_d = '0; phase_d = PH_RD_ACK;
          end else bit_d = bit_q + 3'd1;
        end
      end
      PH_RD_ACK: begin
        last = {1'b0, byte_q} + 5'd1 >= len;
        pull = ~last;
        if (wait_q == 16'd0) begin scl = 1'b0; wait_d = 16'd1; end
        else begin
          wait_d = '0; bit_d = '0;
          if (last) phase_d = PH_RD_STOP;
          else begin byte_d = byte_q + 4'd1; shift_d = '0; phase_d = PH_RD_BITS; end
        end
      end
      PH_DONE: begin
        busy = 1'b0; done = 1'b1;
        if (err_q == ST_OK) begin
          data = {frame_q[2], frame_q[3], frame_q[4], frame_q[5]};
          crc_ok = (frame_q[lm2[IW-1:0]] == crc_q[7:0]) &&
                   (frame_q[lm1[IW-1:0]] == crc_q[15:8]);
        end else data = 32'hffffffff;
        phase_d = PH_IDLE; wait_d = '0; bit_d = '0;
      end
      default: begin phase_d = PH_IDLE; busy = 1'b0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; wait_q <= '0; bit_q <= '0; byte_q <= '0;
      shift_q <= '0; crc_q <= CrcInit; err_q <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d; wait_q <= wait_d; bit_q <= bit_d; byte_q <= byte_d;
      shift_q <= shift_d; crc_q <= crc_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && fr_we) frame_q[byte_q[IW-1:0]] <= fr_wd;
  end

  assign res_o = {crc_ok, data, (done ? err_q : 2'b00), done, busy, pull, scl};
endmodule
`default_nettype wire

FILE: src/sensor_read_i2c_sequencer_top.sv
// two-wire sensor read sequencer, one input request per 10 us tick
// s_axis: tdata = {sda_in, go}; each accepted request advances the bus by one tick
// m_axis: one result per request, tdata from lowest bit: scl_out, sda_pull_low,
//   busy_res, done_res, status[1:0], data_word[31:0], crc_ok
// a request's result is computed in the cycle it is accepted and registered, so
//   it is valid on m_axis from the next cycle, and one request is taken every cycle while
//   m_axis is not stalled; the bound is the single state update of the tick sequencer
// a full output register stalls input only when m_axis_tready is low; the
//   result then holds until taken
// configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i, take
//   effect at the next tick; write only while idle
// reset clears the sequencer to idle, crc to 0xffff and registers to defaults;
//   no result is pending after reset
`default_nettype none
module sensor_read_i2c_sequencer_top import srd_pkg::*; #(
  parameter int FRAME_MAX_BYTES = FrameMaxBytes
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // go, sda_in
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // scl_out, sda_pull_low, busy, done, status, data, crc_ok
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i
);
  logic [7:0]  dev_q;
  logic        kind_q;
  logic [15:0] hold_q, resp_q;
  logic [7:0]  gap_q;
  logic        ov_q;
  logic [38:0] res, res_q;
  logic        acc;

  assign s_axis_tready = !ov_q || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= 8'd184; kind_q <= 1'b0; hold_q <= 16'd200; resp_q <= 16'd200;
      gap_q <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEV_ADDR:  dev_q <= cfg_wdata_i[7:0];
        REG_REQ_KIND:  kind_q <= cfg_wdata_i[0];
        REG_WAKE_HOLD: hold_q <= cfg_wdata_i;
        REG_RESP_WAIT: resp_q <= cfg_wdata_i;
        REG_READ_GAP:  gap_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  srd_seq #(.FRAME_MAX_BYTES(FRAME_MAX_BYTES)) u_seq (
    .clk_i, .rst_ni, .step_i(acc), .go_i(s_axis_tdata[0]), .sda_i(s_axis_tdata[1]),
    .dev_addr_i(dev_q), .req_kind_i(kind_q), .wake_hold_i(hold_q),
    .resp_wait_i(resp_q), .read_gap_i(gap_q), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (acc) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (acc) res_q <= res;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {1'b0, res_q};

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
    else $error("busy and done together");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[5:4] == ST_OK)
    else $error("status outside done tick");
endmodule
`default_nettype wire
